// ===== src/coo_to_csr_converter_macros.svh =====
// ----------------------------------------------------------------------------
// COO to CSR converter assertion macros
// Shared property wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COO_TO_CSR_CONVERTER_MACROS_SVH
`define COO_TO_CSR_CONVERTER_MACROS_SVH

// same-cycle implication
`define C2C_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c2c assertion failed");

// next-cycle implication
`define C2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c2c assertion failed");

`endif

// ===== src/c2c_pkg.sv =====
// ----------------------------------------------------------------------------
// COO to CSR converter package
// Sizes, codes, state encoding and store record layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package c2c_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_ENTRIES = 4096;
  localparam int COLUMN_BITS = 16;
  localparam int VALUE_W     = 64;

  localparam int ROW_W  = $clog2(MAX_ROWS);        // entry row index
  localparam int RPA_W  = $clog2(MAX_ROWS + 1);    // row pointer address / row count
  localparam int ENTA_W = $clog2(MAX_ENTRIES);     // entry store address
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1); // entry count, pointer value
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD       = 2'd0,
    OP_CONVERT    = 2'd1,
    OP_READ_PTR   = 2'd2,
    OP_READ_ENTRY = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_NOTCONV = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLR,
    S_CNT_RD,
    S_CNT_RP,
    S_CNT_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_SCT_RD,
    S_SCT_RF,
    S_SCT_WR,
    S_FIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ROW_W-1:0]       row;
    logic [COLUMN_BITS-1:0] column;
    logic [VALUE_W-1:0]     value;
  } entry_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] column;
    logic [VALUE_W-1:0]     value;
  } sorted_t;

endpackage

`default_nettype wire

// ===== src/c2c_ram.sv =====
// ----------------------------------------------------------------------------
// COO to CSR converter RAM
// One write port, one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/coo_to_csr_converter.sv =====
// ----------------------------------------------------------------------------
// COO to CSR converter
// Stores coordinate entries and converts them to row-compressed form by a
// counting sort on the row index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command item: load an
//   entry, convert, read a row pointer or read a converted entry. Every item
//   returns exactly one result item on the output channel
//   (out_valid_o/out_ready_i). cfg_we_i/cfg_data_i write the row count.
//   Load and read items pass through the dispatch and response steps, and
//   the result is then registered in the output register; the block takes
//   one item at a time and is ready again once the result is in the output
//   register. Convert runs a sequencer over the row pointer RAM and the
//   entry stores: clear the pointers and fill positions of rows 0..rows,
//   count the stored entries per row, prefix sum over the rows and scatter
//   each entry to its sorted place.
//   Reset empties the entry store, clears the row count and marks the block
//   unconverted; no memory sweep is needed at reset.
//   When the receiver stalls, the result holds in the output register and the
//   block can take one more item, which waits in its final step until the
//   output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coo_to_csr_converter_macros.svh"

module coo_to_csr_converter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [c2c_pkg::OP_W-1:0]         opcode_i,
  input  wire logic [c2c_pkg::ROW_W-1:0]        entry_row_i,
  input  wire logic [c2c_pkg::COLUMN_BITS-1:0]  entry_column_i,
  input  wire logic [c2c_pkg::VALUE_W-1:0]      entry_value_i,
  input  wire logic [c2c_pkg::CNT_W-1:0]        read_index_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [c2c_pkg::CNT_W-1:0]        row_pointer_o,
  output logic      [c2c_pkg::COLUMN_BITS-1:0]  out_column_o,
  output logic      [c2c_pkg::VALUE_W-1:0]      out_value_o,
  output logic      [c2c_pkg::CNT_W-1:0]        entry_total_o,
  output logic      [c2c_pkg::STAT_W-1:0]       status_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [c2c_pkg::RPA_W-1:0]        cfg_data_i
);

  localparam int RPA_W  = c2c_pkg::RPA_W;
  localparam int ENTA_W = c2c_pkg::ENTA_W;
  localparam int CNT_W  = c2c_pkg::CNT_W;
  localparam logic [RPA_W-1:0] MaxRows    = RPA_W'(c2c_pkg::MAX_ROWS);
  localparam logic [CNT_W-1:0] MaxEntries = CNT_W'(c2c_pkg::MAX_ENTRIES);

  c2c_pkg::state_e  state_q, state_d;
  c2c_pkg::op_e     op_q;
  c2c_pkg::status_e st_q, st_d;

  logic [c2c_pkg::ROW_W-1:0]       row_q;
  logic [c2c_pkg::COLUMN_BITS-1:0] col_q;
  logic [c2c_pkg::VALUE_W-1:0]     val_q;
  logic [CNT_W-1:0]                idx_q;

  logic [RPA_W-1:0] row_count_q;
  logic [CNT_W-1:0] entry_count_q, entry_count_d;
  logic             converted_q, converted_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [RPA_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] acc_q, acc_d;

  logic [RPA_W-1:0] rows;

  // RAM ports
  logic                  ent_we, ent_re;
  logic [ENTA_W-1:0]     ent_raddr;
  c2c_pkg::entry_t       ent_wdata, ent_rdata;
  logic                  srt_we, srt_re;
  logic [ENTA_W-1:0]     srt_waddr;
  c2c_pkg::sorted_t      srt_wdata, srt_rdata;
  logic                  ptr_we, ptr_re;
  logic [RPA_W-1:0]      ptr_waddr, ptr_raddr;
  logic [CNT_W-1:0]      ptr_wdata, ptr_rdata;
  logic                  fil_we, fil_re;
  logic [RPA_W-1:0]      fil_waddr, fil_raddr;
  logic [CNT_W-1:0]      fil_wdata, fil_rdata;

  logic             in_take;
  logic             out_load;
  logic             row_in_use;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] pfx_sum;
  logic [CNT_W-1:0] res_ptr;
  c2c_pkg::sorted_t res_ent;

  assign rows       = (row_count_q > MaxRows) ? MaxRows : row_count_q;
  assign in_ready_o = (state_q == c2c_pkg::S_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign row_in_use = ({1'b0, ent_rdata.row} < rows);
  assign i_next     = i_q + CNT_W'(1);
  assign pfx_sum    = acc_q + ptr_rdata;
  assign out_load   = (state_q == c2c_pkg::S_RESP) && (!out_valid_o || out_ready_i);

  c2c_ram #(.WIDTH($bits(c2c_pkg::entry_t)), .DEPTH(c2c_pkg::MAX_ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (entry_count_q[ENTA_W-1:0]),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  c2c_ram #(.WIDTH($bits(c2c_pkg::sorted_t)), .DEPTH(c2c_pkg::MAX_ENTRIES)) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (srt_we),
    .waddr_i (srt_waddr),
    .wdata_i (srt_wdata),
    .re_i    (srt_re),
    .raddr_i (idx_q[ENTA_W-1:0]),
    .rdata_o (srt_rdata)
  );

  c2c_ram #(.WIDTH(CNT_W), .DEPTH(c2c_pkg::MAX_ROWS + 1)) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .re_i    (ptr_re),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  c2c_ram #(.WIDTH(CNT_W), .DEPTH(c2c_pkg::MAX_ROWS + 1)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fil_we),
    .waddr_i (fil_waddr),
    .wdata_i (fil_wdata),
    .re_i    (fil_re),
    .raddr_i (fil_raddr),
    .rdata_o (fil_rdata)
  );

  always_comb begin
    state_d       = state_q;
    st_d          = st_q;
    entry_count_d = entry_count_q;
    converted_d   = converted_q;
    total_d       = total_q;
    k_d           = k_q;
    i_d           = i_q;
    acc_d         = acc_q;

    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_raddr = i_q[ENTA_W-1:0];
    ent_wdata = '{row: row_q, column: col_q, value: val_q};
    srt_we    = 1'b0;
    srt_re    = 1'b0;
    srt_waddr = fil_rdata[ENTA_W-1:0];
    srt_wdata = '{column: ent_rdata.column, value: ent_rdata.value};
    ptr_we    = 1'b0;
    ptr_re    = 1'b0;
    ptr_waddr = k_q;
    ptr_raddr = k_q;
    ptr_wdata = '0;
    fil_we    = 1'b0;
    fil_re    = 1'b0;
    fil_waddr = k_q;
    fil_raddr = {1'b0, ent_rdata.row};
    fil_wdata = '0;

    case (state_q)
      c2c_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = c2c_pkg::S_DISPATCH;
        end
      end
      c2c_pkg::S_DISPATCH: begin
        st_d    = c2c_pkg::STAT_OK;
        state_d = c2c_pkg::S_RESP;
        case (op_q)
          c2c_pkg::OP_LOAD: begin
            if ({1'b0, row_q} >= rows) begin
              st_d = c2c_pkg::STAT_RANGE;
            end else if (entry_count_q == MaxEntries) begin
              st_d = c2c_pkg::STAT_FULL;
            end else begin
              ent_we        = 1'b1;
              entry_count_d = entry_count_q + CNT_W'(1);
              converted_d   = 1'b0;
            end
          end
          c2c_pkg::OP_CONVERT: begin
            k_d     = '0;
            state_d = c2c_pkg::S_CLR;
          end
          c2c_pkg::OP_READ_PTR: begin
            ptr_raddr = idx_q[RPA_W-1:0];
            if (!converted_q) begin
              st_d = c2c_pkg::STAT_NOTCONV;
            end else if (idx_q > CNT_W'(rows)) begin
              st_d = c2c_pkg::STAT_RANGE;
            end else begin
              ptr_re = 1'b1;
            end
          end
          default: begin
            if (!converted_q) begin
              st_d = c2c_pkg::STAT_NOTCONV;
            end else if (idx_q >= total_q || idx_q >= MaxEntries) begin
              st_d = c2c_pkg::STAT_RANGE;
            end else begin
              srt_re = 1'b1;
            end
          end
        endcase
      end
      // zero pointers and fill positions for rows 0..rows
      c2c_pkg::S_CLR: begin
        ptr_we = 1'b1;
        fil_we = 1'b1;
        k_d    = k_q + RPA_W'(1);
        if (k_q == rows) begin
          i_d = '0;
          if (entry_count_q == '0) begin
            k_d     = RPA_W'(1);
            acc_d   = '0;
            state_d = (rows == '0) ? c2c_pkg::S_FIN : c2c_pkg::S_PFX_RD;
          end else begin
            state_d = c2c_pkg::S_CNT_RD;
          end
        end
      end
      c2c_pkg::S_CNT_RD: begin
        ent_re  = 1'b1;
        state_d = c2c_pkg::S_CNT_RP;
      end
      c2c_pkg::S_CNT_RP: begin
        ptr_raddr = {1'b0, ent_rdata.row} + RPA_W'(1);
        if (row_in_use) begin
          ptr_re  = 1'b1;
          state_d = c2c_pkg::S_CNT_WR;
        end else begin
          i_d = i_next;
          if (i_next == entry_count_q) begin
            k_d     = RPA_W'(1);
            acc_d   = '0;
            state_d = (rows == '0) ? c2c_pkg::S_FIN : c2c_pkg::S_PFX_RD;
          end else begin
            state_d = c2c_pkg::S_CNT_RD;
          end
        end
      end
      c2c_pkg::S_CNT_WR: begin
        ptr_we    = 1'b1;
        ptr_waddr = {1'b0, ent_rdata.row} + RPA_W'(1);
        ptr_wdata = ptr_rdata + CNT_W'(1);
        i_d       = i_next;
        if (i_next == entry_count_q) begin
          k_d     = RPA_W'(1);
          acc_d   = '0;
          state_d = (rows == '0) ? c2c_pkg::S_FIN : c2c_pkg::S_PFX_RD;
        end else begin
          state_d = c2c_pkg::S_CNT_RD;
        end
      end
      c2c_pkg::S_PFX_RD: begin
        ptr_re  = 1'b1;
        state_d = c2c_pkg::S_PFX_WR;
      end
      c2c_pkg::S_PFX_WR: begin
        ptr_we    = 1'b1;
        ptr_wdata = pfx_sum;
        fil_we    = 1'b1;
        fil_wdata = pfx_sum;
        acc_d     = pfx_sum;
        k_d       = k_q + RPA_W'(1);
        if (k_q == rows) begin
          i_d     = '0;
          state_d = (entry_count_q == '0) ? c2c_pkg::S_FIN : c2c_pkg::S_SCT_RD;
        end else begin
          state_d = c2c_pkg::S_PFX_RD;
        end
      end
      c2c_pkg::S_SCT_RD: begin
        ent_re  = 1'b1;
        state_d = c2c_pkg::S_SCT_RF;
      end
      c2c_pkg::S_SCT_RF: begin
        if (row_in_use) begin
          fil_re  = 1'b1;
          state_d = c2c_pkg::S_SCT_WR;
        end else begin
          i_d     = i_next;
          state_d = (i_next == entry_count_q) ? c2c_pkg::S_FIN : c2c_pkg::S_SCT_RD;
        end
      end
      // place the entry and advance its row's fill position
      c2c_pkg::S_SCT_WR: begin
        srt_we    = 1'b1;
        fil_we    = 1'b1;
        fil_waddr = {1'b0, ent_rdata.row};
        fil_wdata = fil_rdata + CNT_W'(1);
        i_d       = i_next;
        state_d   = (i_next == entry_count_q) ? c2c_pkg::S_FIN : c2c_pkg::S_SCT_RD;
      end
      c2c_pkg::S_FIN: begin
        total_d     = acc_q;
        converted_d = 1'b1;
        st_d        = c2c_pkg::STAT_OK;
        state_d     = c2c_pkg::S_RESP;
      end
      c2c_pkg::S_RESP: begin
        if (out_load) begin
          state_d = c2c_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = c2c_pkg::S_IDLE;
      end
    endcase

    // a row count write drops the conversion
    if (cfg_we_i) begin
      converted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= c2c_pkg::S_IDLE;
      row_count_q   <= '0;
      entry_count_q <= '0;
      converted_q   <= 1'b0;
      out_valid_o   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      converted_q   <= converted_d;
      if (cfg_we_i) begin
        row_count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    total_q <= total_d;
    k_q     <= k_d;
    i_q     <= i_d;
    acc_q   <= acc_d;
    if (in_take) begin
      op_q  <= c2c_pkg::op_e'(opcode_i);
      row_q <= entry_row_i;
      col_q <= entry_column_i;
      val_q <= entry_value_i;
      idx_q <= read_index_i;
    end
  end

  always_comb begin
    res_ptr = '0;
    res_ent = '0;
    if (op_q == c2c_pkg::OP_CONVERT) begin
      res_ptr = total_q;
    end else if (st_q == c2c_pkg::STAT_OK && op_q == c2c_pkg::OP_READ_PTR) begin
      res_ptr = ptr_rdata;
    end else if (st_q == c2c_pkg::STAT_OK && op_q == c2c_pkg::OP_READ_ENTRY) begin
      res_ent = srt_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      row_pointer_o <= res_ptr;
      out_column_o  <= res_ent.column;
      out_value_o   <= res_ent.value;
      entry_total_o <= entry_count_q;
      status_o      <= st_q;
    end
  end

  `C2C_ASSERT_IMPL(a_count_bound, 1'b1, entry_count_q <= MaxEntries)
  `C2C_ASSERT_NEXT(a_one_at_a_time, in_take, !in_ready_o)
  `C2C_ASSERT_IMPL(a_total_bound, converted_q && state_q == c2c_pkg::S_IDLE, total_q <= entry_count_q)
  `C2C_ASSERT_IMPL(a_scatter_bound, state_q == c2c_pkg::S_SCT_WR, fil_rdata < acc_q)

endmodule

`default_nettype wire
